// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i with reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LEB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define LEB_ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define LEB_ASSERT(name, prop)
`define LEB_ASSERT_NEVER(name, prop)
`endif
`endif

// File: hw/rtl/leb_pkg.sv
package leb_pkg;

  localparam int unsigned TOT_W  = 16;
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned FAC_W  = 13;
  localparam int unsigned OUT_W  = 28;
  localparam int unsigned STEP_W = 25;
  localparam int unsigned PROD_W = 41;

  localparam logic [FAC_W-1:0] FULL_FACTOR = 13'd4096;
  localparam logic [NUM_W-1:0] BREATH_NUM  = 28'd20971520;
  localparam logic [TOT_W-1:0] TOT_RESET   = 16'd1000;
  localparam logic [TOT_W-1:0] TOT_MIN     = 16'd1;

  typedef enum logic [2:0] {
    FUNC_BREATH,
    FUNC_FADEIN40,
    FUNC_FADEIN80,
    FUNC_FADEOUT40,
    FUNC_FADEOUT80,
    FUNC_LINEAR,
    FUNC_BLINK,
    FUNC_KEEP
  } func_e;

  localparam logic [FAC_W-1:0] BREATH_TAB [80] = '{
    13'd0, 13'd52, 13'd104, 13'd156, 13'd207, 13'd259, 13'd311, 13'd363,
    13'd415, 13'd467, 13'd518, 13'd570, 13'd622, 13'd674, 13'd726, 13'd778,
    13'd829, 13'd881, 13'd933, 13'd985, 13'd1037, 13'd1089, 13'd1140, 13'd1192,
    13'd1244, 13'd1296, 13'd1348, 13'd1400, 13'd1451, 13'd1503, 13'd1555, 13'd1607,
    13'd1659, 13'd1711, 13'd1763, 13'd1815, 13'd1866, 13'd1918, 13'd1970, 13'd2022,
    13'd2074, 13'd2126, 13'd2177, 13'd2229, 13'd2281, 13'd2333, 13'd2385, 13'd2437,
    13'd2488, 13'd2540, 13'd2592, 13'd2644, 13'd2696, 13'd2748, 13'd2800, 13'd2851,
    13'd2903, 13'd2955, 13'd3007, 13'd3059, 13'd3111, 13'd3163, 13'd3214, 13'd3266,
    13'd3318, 13'd3370, 13'd3422, 13'd3474, 13'd3526, 13'd3577, 13'd3629, 13'd3681,
    13'd3733, 13'd3785, 13'd3837, 13'd3889, 13'd3940, 13'd3992, 13'd4044, 13'd4096
  };

  localparam logic [FAC_W-1:0] FADE40_TAB [40] = '{
    13'd0, 13'd31, 13'd75, 13'd131, 13'd197, 13'd272, 13'd355, 13'd445,
    13'd541, 13'd641, 13'd745, 13'd852, 13'd961, 13'd1073, 13'd1185, 13'd1298,
    13'd1412, 13'd1526, 13'd1641, 13'd1755, 13'd1869, 13'd1983, 13'd2097, 13'd2210,
    13'd2323, 13'd2435, 13'd2547, 13'd2657, 13'd2768, 13'd2877, 13'd2987, 13'd3095,
    13'd3203, 13'd3311, 13'd3419, 13'd3526, 13'd3634, 13'd3741, 13'd3849, 13'd4096
  };

  localparam logic [FAC_W-1:0] FADEIN80_TAB [80] = '{
    13'd0, 13'd0, 13'd0, 13'd0, 13'd1, 13'd1, 13'd2, 13'd3,
    13'd4, 13'd6, 13'd8, 13'd11, 13'd14, 13'd18, 13'd23, 13'd28,
    13'd34, 13'd41, 13'd48, 13'd57, 13'd66, 13'd77, 13'd88, 13'd101,
    13'd115, 13'd130, 13'd146, 13'd164, 13'd182, 13'd203, 13'd224, 13'd247,
    13'd272, 13'd299, 13'd327, 13'd356, 13'd388, 13'd421, 13'd456, 13'd493,
    13'd532, 13'd573, 13'd615, 13'd661, 13'd708, 13'd757, 13'd809, 13'd863,
    13'd919, 13'd977, 13'd1038, 13'd1102, 13'd1168, 13'd1237, 13'd1308, 13'd1382,
    13'd1459, 13'd1539, 13'd1621, 13'd1706, 13'd1794, 13'd1886, 13'd1980, 13'd2077,
    13'd2178, 13'd2281, 13'd2388, 13'd2499, 13'd2612, 13'd2729, 13'd2850, 13'd2973,
    13'd3101, 13'd3232, 13'd3366, 13'd3505, 13'd3647, 13'd3793, 13'd3942, 13'd4096
  };

  localparam logic [FAC_W-1:0] FADEOUT80_TAB [80] = '{
    13'd0, 13'd154, 13'd303, 13'd449, 13'd591, 13'd730, 13'd864, 13'd995,
    13'd1123, 13'd1246, 13'd1367, 13'd1484, 13'd1597, 13'd1708, 13'd1815, 13'd1918,
    13'd2019, 13'd2116, 13'd2210, 13'd2302, 13'd2390, 13'd2475, 13'd2557, 13'd2637,
    13'd2714, 13'd2788, 13'd2859, 13'd2928, 13'd2994, 13'd3058, 13'd3119, 13'd3177,
    13'd3233, 13'd3287, 13'd3339, 13'd3388, 13'd3435, 13'd3481, 13'd3523, 13'd3564,
    13'd3603, 13'd3640, 13'd3675, 13'd3708, 13'd3740, 13'd3769, 13'd3797, 13'd3824,
    13'd3849, 13'd3872, 13'd3893, 13'd3914, 13'd3932, 13'd3950, 13'd3966, 13'd3981,
    13'd3995, 13'd4008, 13'd4019, 13'd4030, 13'd4039, 13'd4048, 13'd4055, 13'd4062,
    13'd4068, 13'd4073, 13'd4078, 13'd4082, 13'd4085, 13'd4088, 13'd4090, 13'd4092,
    13'd4093, 13'd4094, 13'd4095, 13'd4095, 13'd4096, 13'd4096, 13'd4096, 13'd4096
  };

endpackage

// File: hw/rtl/leb_div.sv
module leb_div #(
  parameter int unsigned SIDE_W = 51
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [leb_pkg::NUM_W-1:0]  num_i,
  input  logic [leb_pkg::TOT_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [leb_pkg::NUM_W-1:0]  quot_o,
  output logic [SIDE_W-1:0]          side_o
);
  import leb_pkg::*;

  logic [NUM_W-1:0] v_q;
  logic [NUM_W:0]   adv;
  logic [TOT_W-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0] nq_q   [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  assign adv[NUM_W] = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              prev_v;
    logic [TOT_W-1:0]  prev_rem;
    logic [NUM_W-1:0]  prev_nq;
    logic [SIDE_W-1:0] prev_side;
    logic [TOT_W:0]    trial;
    logic              ge;
    logic [TOT_W:0]    diff;
    logic [TOT_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign prev_v    = in_valid_i;
      assign prev_rem  = '0;
      assign prev_nq   = num_i;
      assign prev_side = side_i;
    end else begin : g_rest
      assign prev_v    = v_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_nq   = nq_q[k-1];
      assign prev_side = side_q[k-1];
    end

    assign adv[k] = ~v_q[k] | adv[k+1];
    assign trial  = {prev_rem, prev_nq[NUM_W-1]};
    assign ge     = trial >= {1'b0, den_i};
    assign diff   = trial - {1'b0, den_i};
    assign rem_d  = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        rem_q[k]  <= rem_d;
        nq_q[k]   <= {prev_nq[NUM_W-2:0], ge};
        side_q[k] <= prev_side;
      end
    end
  end

  assign out_valid_o = v_q[NUM_W-1];
  assign quot_o      = nq_q[NUM_W-1];
  assign side_o      = side_q[NUM_W-1];

endmodule

// File: hw/rtl/leb_tail.sv
module leb_tail #(
  parameter int unsigned VB = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [leb_pkg::NUM_W-1:0]  quot_i,
  input  logic [2:0]                 func_i,
  input  logic [VB-1:0]              start_i,
  input  logic [VB-1:0]              end_i,
  input  logic [leb_pkg::TOT_W-1:0]  elapsed_i,
  input  logic [leb_pkg::TOT_W-1:0]  tot_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [leb_pkg::OUT_W-1:0]  scaled_o,
  output logic [leb_pkg::FAC_W-1:0]  factor_o
);
  import leb_pkg::*;

  localparam int unsigned NST   = 4;
  localparam int unsigned MUL_W = FAC_W + VB;
  localparam int unsigned SUM_W = (VB + 14 > OUT_W) ? VB + 14 : OUT_W;

  logic [NST-1:0] v_q;
  logic [NST:0]   adv;
  logic [NST-1:0] vin;

  logic [2:0]        func0_q;
  logic [VB-1:0]     s0_q, e0_q;
  logic [TOT_W-1:0]  el0_q;
  logic [NUM_W-1:0]  q0_q;
  logic [PROD_W-1:0] prod0_q;
  logic [PROD_W-1:0] prod_d;

  logic [VB-1:0]    s1_q, e1_q, s1_d;
  logic [FAC_W-1:0] f1_q, f1_d;

  logic [VB-1:0]    s2_q;
  logic             up2_q;
  logic [MUL_W-1:0] p2_q;
  logic [FAC_W-1:0] f2_q;
  logic             up_d;
  logic [VB-1:0]    diff_d;

  logic [OUT_W-1:0] sc3_q;
  logic [FAC_W-1:0] f3_q;
  logic [SUM_W-1:0] base_d, pw_d, sum_d;

  logic [STEP_W-1:0] bidx;
  logic              el_ge;
  logic [6:0]        fidx40, fidx80, qdec;
  logic [7:0]        bmir;

  assign vin        = {v_q[NST-2:0], in_valid_i};
  assign adv[NST]   = out_ready_i;
  assign in_ready_o = adv[0];
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = ~v_q[k] | adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign prod_d = elapsed_i * quot_i[STEP_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      func0_q <= func_i;
      s0_q    <= start_i;
      e0_q    <= end_i;
      el0_q   <= elapsed_i;
      q0_q    <= quot_i;
      prod0_q <= prod_d;
    end
  end

  assign bidx   = prod0_q[PROD_W-1:16];
  assign bmir   = 8'd239 - bidx[7:0];
  assign el_ge  = el0_q >= tot_i;
  assign qdec   = (q0_q[6:0] == 7'd0) ? 7'd0 : q0_q[6:0] - 7'd1;
  assign fidx40 = el_ge ? 7'd39 : qdec;
  assign fidx80 = el_ge ? 7'd79 : qdec;

  always_comb begin
    s1_d = s0_q;
    case (func_e'(func0_q))
      FUNC_BREATH: begin
        if (bidx < STEP_W'(80)) begin
          f1_d = BREATH_TAB[bidx[6:0]];
        end else if (bidx < STEP_W'(160)) begin
          f1_d = FULL_FACTOR;
        end else if (bidx < STEP_W'(240)) begin
          f1_d = BREATH_TAB[bmir[6:0]];
        end else begin
          f1_d = '0;
        end
      end
      FUNC_FADEIN40, FUNC_FADEOUT40: f1_d = FADE40_TAB[fidx40[5:0]];
      FUNC_FADEIN80:  f1_d = FADEIN80_TAB[fidx80];
      FUNC_FADEOUT80: f1_d = FADEOUT80_TAB[fidx80];
      FUNC_LINEAR:    f1_d = el_ge ? FULL_FACTOR : q0_q[FAC_W-1:0];
      FUNC_BLINK: begin
        f1_d = (el0_q < (tot_i >> 1)) ? FULL_FACTOR : '0;
        s1_d = '0;
      end
      default: f1_d = FULL_FACTOR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_q <= s1_d;
      e1_q <= e0_q;
      f1_q <= f1_d;
    end
  end

  assign up_d   = e1_q >= s1_q;
  assign diff_d = up_d ? e1_q - s1_q : s1_q - e1_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_q  <= s1_q;
      up2_q <= up_d;
      p2_q  <= f1_q * diff_d;
      f2_q  <= f1_q;
    end
  end

  assign base_d = {{(SUM_W-VB-12){1'b0}}, s2_q, 12'b0};
  assign pw_d   = {{(SUM_W-MUL_W){1'b0}}, p2_q};
  assign sum_d  = up2_q ? base_d + pw_d : base_d - pw_d;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sc3_q <= sum_d[OUT_W-1:0];
      f3_q  <= f2_q;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign scaled_o    = sc3_q;
  assign factor_o    = f3_q;

endmodule

// File: hw/rtl/led_easing_blend_core.sv
// Channel   Handshake                  Beat fields
// input     in_valid_i / in_ready_o    func_i, start_value_i, end_value_i, elapsed_ms_i
// output    out_valid_o / out_ready_i  scaled_value_o, curve_factor_o
// config    cfg_we_i                   cfg_wdata_i (total_ms)
//
// One beat enters per cycle while in_ready_o is high; from acceptance to output each beat passes through:
// 28 stages of a one-bit-per-stage divider, then four stages for the curve product,
// table lookup, blend multiply and final add.
// Reset clears all valid bits and loads total_ms with 1000.
// A stall at the output backs up only through full stages; empty stages keep filling.
module led_easing_blend_core #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] start_value_i,
  input  logic [15:0] end_value_i,
  input  logic [15:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [27:0] scaled_value_o,
  output logic [12:0] curve_factor_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import leb_pkg::*;

  localparam int unsigned SIDE_W = 3 + 2 * VALUE_BITS + TOT_W;

  logic [TOT_W-1:0]      total_ms_q;
  logic [NUM_W-1:0]      num_d;
  logic [NUM_W-1:0]      el_w;
  logic [VALUE_BITS+15:0] s_wide, e_wide;
  logic [SIDE_W-1:0]     side_in, side_out;
  logic                  dv_valid, dv_ready;
  logic [NUM_W-1:0]      quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_ms_q <= TOT_RESET;
    end else if (cfg_we_i) begin
      total_ms_q <= (cfg_wdata_i == '0) ? TOT_MIN : cfg_wdata_i;
    end
  end

  assign el_w = NUM_W'(elapsed_ms_i);

  always_comb begin
    case (func_e'(func_i))
      FUNC_BREATH:                   num_d = BREATH_NUM;
      FUNC_FADEIN40, FUNC_FADEOUT40: num_d = (el_w << 5) + (el_w << 3);
      FUNC_FADEIN80, FUNC_FADEOUT80: num_d = (el_w << 6) + (el_w << 4);
      FUNC_LINEAR:                   num_d = el_w << 12;
      default:                       num_d = '0;
    endcase
  end

  assign s_wide  = {{VALUE_BITS{1'b0}}, start_value_i};
  assign e_wide  = {{VALUE_BITS{1'b0}}, end_value_i};
  assign side_in = {func_i, s_wide[VALUE_BITS-1:0], e_wide[VALUE_BITS-1:0], elapsed_ms_i};

  leb_div #(
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .num_i      (num_d),
    .den_i      (total_ms_q),
    .side_i     (side_in),
    .out_valid_o(dv_valid),
    .out_ready_i(dv_ready),
    .quot_o     (quot),
    .side_o     (side_out)
  );

  leb_tail #(
    .VB(VALUE_BITS)
  ) u_tail (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dv_valid),
    .in_ready_o (dv_ready),
    .quot_i     (quot),
    .func_i     (side_out[SIDE_W-1 -: 3]),
    .start_i    (side_out[SIDE_W-4 -: VALUE_BITS]),
    .end_i      (side_out[TOT_W+VALUE_BITS-1 -: VALUE_BITS]),
    .elapsed_i  (side_out[TOT_W-1:0]),
    .tot_i      (total_ms_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .scaled_o   (scaled_value_o),
    .factor_o   (curve_factor_o)
  );

`include "assert_macros.svh"

  `LEB_ASSERT_NEVER(a_tot_zero, total_ms_q == '0)
  `LEB_ASSERT(a_factor_range, out_valid_o |-> curve_factor_o <= FULL_FACTOR)
  `LEB_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule
